FILE: design/bmpd_pkg.sv
// bmpd_pkg: shared types, sizes and codes for the BMP stream deframer.
// Used by the result interface, the parser, the output stage and the top level.
// No dependencies.
package bmpd_pkg;

  // Largest accepted image width or height
  localparam int unsigned MAX_DIM = 4096;

  // Width/height register size (holds MAX_DIM itself)
  localparam int DIM_W = $clog2(MAX_DIM + 1);
  // Row/column counter size; also numbers up to 256 palette entries
  localparam int CNT_W = ($clog2(MAX_DIM) > 9) ? $clog2(MAX_DIM) : 9;
  // Common width for counter vs. dimension compares
  localparam int CMP_W = ((CNT_W + 1) > DIM_W) ? (CNT_W + 1) : DIM_W;

  // Result field widths
  localparam int POS_W = 12;

  // Result kinds
  localparam logic [1:0] KIND_PALETTE = 2'd0;
  localparam logic [1:0] KIND_PIXEL   = 2'd1;
  localparam logic [1:0] KIND_ERROR   = 2'd2;

  // Format error codes
  localparam logic [2:0] ERR_MAGIC    = 3'd0;
  localparam logic [2:0] ERR_HDR_SIZE = 3'd1;
  localparam logic [2:0] ERR_PLANES   = 3'd2;
  localparam logic [2:0] ERR_DEPTH    = 3'd3;
  localparam logic [2:0] ERR_COMPRESS = 3'd4;
  localparam logic [2:0] ERR_SIZE     = 3'd5;

  // One result transaction
  typedef struct packed {
    logic [1:0]       kind;
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
    logic [7:0]       colour_index;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] column;
    logic             last_pixel;
    logic [2:0]       error_code;
  } bmpd_result_t;

endpackage

FILE: design/bmpd_if.sv
// bmpd_if: valid/ready channel interfaces for the BMP stream deframer.
// bmpd_in_if carries file bytes, bmpd_out_if carries result transactions.
// Depends on bmpd_pkg.
interface bmpd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       file_start;

  modport source (output valid, output data_byte, output file_start, input ready);
  modport sink   (input valid, input data_byte, input file_start, output ready);
endinterface

interface bmpd_out_if import bmpd_pkg::*;;
  logic             valid;
  logic             ready;
  logic [1:0]       kind;
  logic [7:0]       red;
  logic [7:0]       green;
  logic [7:0]       blue;
  logic [7:0]       colour_index;
  logic [POS_W-1:0] row;
  logic [POS_W-1:0] column;
  logic             last_pixel;
  logic [2:0]       error_code;

  modport source (output valid, output kind, output red, output green, output blue,
                  output colour_index, output row, output column, output last_pixel,
                  output error_code, input ready);
  modport sink   (input valid, input kind, input red, input green, input blue,
                  input colour_index, input row, input column, input last_pixel,
                  input error_code, output ready);
endinterface

FILE: design/bmp_stream_deframer.sv
// bmp_stream_deframer: top level of the streaming BMP (8/24-bit) parser.
// Depends on bmpd_pkg, bmpd_if, bmpd_parser and bmpd_out_stage.
//
// Takes a BMP file one byte per transaction (file_start marks byte 0) and
// returns format errors, palette entries and pixels with their row and
// column, row 0 at the top. Each byte is handled by the parser state
// machine; its result, if any, sits in a single output register, so
// the block accepts one byte per clock as long as results are taken. When a
// result is held and the result channel stalls, input ready drops until it
// is taken. A result appears in the cycle after the byte that causes it.
module bmp_stream_deframer import bmpd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  bmpd_in_if.sink     in_chan,
  bmpd_out_if.source  out_chan
);

  logic         in_accept;
  logic         stage_ready;
  logic         res_valid;
  bmpd_result_t res;

  assign in_chan.ready = stage_ready;
  assign in_accept     = in_chan.valid && stage_ready;

  // Byte parser
  bmpd_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (in_accept),
    .data_byte  (in_chan.data_byte),
    .file_start (in_chan.file_start),
    .res_valid  (res_valid),
    .res        (res)
  );

  // Result register
  bmpd_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (in_accept),
    .res_valid (res_valid),
    .res       (res),
    .ready_up  (stage_ready),
    .out_chan  (out_chan)
  );

endmodule

FILE: design/bmpd_parser.sv
// bmpd_parser: per-byte header, palette and pixel parsing state machine.
// One accepted byte updates the state and yields at most one result.
// Depends on bmpd_pkg.
module bmpd_parser import bmpd_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         step,
  input  logic [7:0]   data_byte,
  input  logic         file_start,
  output logic         res_valid,
  output bmpd_result_t res
);

  typedef enum logic [2:0] {
    PH_IDLE, PH_HEADER, PH_PALETTE, PH_PIXELS, PH_DONE, PH_ERROR
  } phase_t;

  // Header byte positions and expected values
  localparam logic [31:0] POS_MAGIC_B  = 32'd0;
  localparam logic [31:0] POS_MAGIC_M  = 32'd1;
  localparam logic [31:0] POS_OFFSET   = 32'd13;
  localparam logic [31:0] POS_HDR_SIZE = 32'd17;
  localparam logic [31:0] POS_WIDTH    = 32'd21;
  localparam logic [31:0] POS_HEIGHT   = 32'd25;
  localparam logic [31:0] POS_PLANES   = 32'd27;
  localparam logic [31:0] POS_DEPTH    = 32'd29;
  localparam logic [31:0] POS_COMPRESS = 32'd33;
  localparam logic [31:0] POS_COLOURS  = 32'd49;
  localparam logic [31:0] POS_HDR_END  = 32'd53;
  localparam logic [7:0]  CHAR_B       = 8'h42;
  localparam logic [7:0]  CHAR_M       = 8'h4D;
  localparam logic [31:0] INFO_SIZE    = 32'd40;
  localparam logic [31:0] DEPTH_8      = 32'd8;
  localparam logic [31:0] DEPTH_24     = 32'd24;
  localparam logic [8:0]  PAL_FULL     = 9'd256;

  phase_t             phase_r, phase_nxt, phase_cur;
  logic [31:0]        pos_r, pos_nxt, pos_cur;
  logic [31:0]        shift_r, shift_nxt;
  logic [DIM_W-1:0]   width_r, width_nxt;
  logic [DIM_W-1:0]   height_r, height_nxt;
  logic [31:0]        offset_r, offset_nxt;
  logic               true_col_r, true_col_nxt;
  logic [8:0]         pal_cnt_r, pal_cnt_nxt;
  logic [15:0]        comp_buf_r, comp_buf_nxt;
  logic [1:0]         comp_cnt_r, comp_cnt_nxt;
  logic [CNT_W-1:0]   row_r, row_nxt;
  logic [CNT_W-1:0]   col_r, col_nxt;
  logic [1:0]         pad_r, pad_nxt;

  logic               in_field;
  logic [1:0]         lane;
  logic               enter_pix;
  logic               emit_pix;
  logic [7:0]         pix_red, pix_green, pix_blue, pix_idx;
  logic               fail;
  logic [2:0]         fail_code;
  logic [CMP_W-1:0]   col_inc;
  logic [DIM_W-1:0]   height_m1;

  assign col_inc   = CMP_W'(col_r) + CMP_W'(1);
  assign height_m1 = height_r - DIM_W'(1);

  // Restart view: a file start abandons the current file at once
  assign phase_cur = file_start ? PH_HEADER : phase_r;
  assign pos_cur   = file_start ? 32'd0 : pos_r;

  // Which little-endian header field this byte belongs to, and its byte lane
  always_comb begin
    in_field = 1'b0;
    lane     = 2'd0;
    if (pos_cur >= 32'd10 && pos_cur < 32'd26) begin
      in_field = 1'b1;
      lane     = 2'(pos_cur - 32'd10);
    end else if (pos_cur >= 32'd26 && pos_cur < 32'd30) begin
      in_field = 1'b1;
      lane     = {1'b0, pos_cur[0]};
    end else if (pos_cur >= 32'd30 && pos_cur < 32'd34) begin
      in_field = 1'b1;
      lane     = 2'(pos_cur - 32'd30);
    end else if (pos_cur >= 32'd46 && pos_cur < 32'd50) begin
      in_field = 1'b1;
      lane     = 2'(pos_cur - 32'd46);
    end
  end

  // Next state and result
  always_comb begin
    phase_nxt    = phase_r;
    pos_nxt      = pos_r;
    shift_nxt    = shift_r;
    width_nxt    = width_r;
    height_nxt   = height_r;
    offset_nxt   = offset_r;
    true_col_nxt = true_col_r;
    pal_cnt_nxt  = pal_cnt_r;
    comp_buf_nxt = comp_buf_r;
    comp_cnt_nxt = comp_cnt_r;
    row_nxt      = row_r;
    col_nxt      = col_r;
    pad_nxt      = pad_r;
    enter_pix    = 1'b0;
    emit_pix     = 1'b0;
    pix_red      = 8'd0;
    pix_green    = 8'd0;
    pix_blue     = 8'd0;
    pix_idx      = 8'd0;
    fail         = 1'b0;
    fail_code    = ERR_MAGIC;
    res_valid    = 1'b0;
    res          = '0;

    if (step && (phase_cur == PH_HEADER || phase_cur == PH_PALETTE ||
                 phase_cur == PH_PIXELS)) begin
      phase_nxt = phase_cur;
      pos_nxt   = (pos_cur == '1) ? pos_cur : pos_cur + 32'd1;

      unique case (phase_cur)
        PH_HEADER: begin
          // Gather field bytes
          if (in_field) begin
            if (lane == 2'd0) begin
              shift_nxt = {24'd0, data_byte};
            end else begin
              shift_nxt = shift_r | (32'(data_byte) << {lane, 3'b000});
            end
          end
          // Checks and captures at the last byte of each field
          unique case (pos_cur)
            POS_MAGIC_B: begin
              if (data_byte != CHAR_B) begin
                fail      = 1'b1;
                fail_code = ERR_MAGIC;
              end
            end
            POS_MAGIC_M: begin
              if (data_byte != CHAR_M) begin
                fail      = 1'b1;
                fail_code = ERR_MAGIC;
              end
            end
            POS_OFFSET: offset_nxt = shift_nxt;
            POS_HDR_SIZE: begin
              if (shift_nxt != INFO_SIZE) begin
                fail      = 1'b1;
                fail_code = ERR_HDR_SIZE;
              end
            end
            POS_WIDTH: begin
              if (shift_nxt > 32'(MAX_DIM)) begin
                fail      = 1'b1;
                fail_code = ERR_SIZE;
              end else begin
                width_nxt = DIM_W'(shift_nxt);
              end
            end
            POS_HEIGHT: begin
              if (shift_nxt > 32'(MAX_DIM)) begin
                fail      = 1'b1;
                fail_code = ERR_SIZE;
              end else begin
                height_nxt = DIM_W'(shift_nxt);
              end
            end
            POS_PLANES: begin
              if (shift_nxt != 32'd1) begin
                fail      = 1'b1;
                fail_code = ERR_PLANES;
              end
            end
            POS_DEPTH: begin
              if (shift_nxt == DEPTH_8) begin
                true_col_nxt = 1'b0;
              end else if (shift_nxt == DEPTH_24) begin
                true_col_nxt = 1'b1;
              end else begin
                fail      = 1'b1;
                fail_code = ERR_DEPTH;
              end
            end
            POS_COMPRESS: begin
              if (shift_nxt != 32'd0) begin
                fail      = 1'b1;
                fail_code = ERR_COMPRESS;
              end
            end
            POS_COLOURS: begin
              // Zero or more than 256 colours means a full palette
              if (shift_nxt == 32'd0 || shift_nxt > 32'(PAL_FULL)) begin
                pal_cnt_nxt = PAL_FULL;
              end else begin
                pal_cnt_nxt = 9'(shift_nxt);
              end
            end
            POS_HDR_END: begin
              if (true_col_r) begin
                enter_pix = 1'b1;
              end else begin
                phase_nxt    = PH_PALETTE;
                col_nxt      = '0;
                comp_cnt_nxt = 2'd0;
                comp_buf_nxt = 16'd0;
              end
            end
            default: ;
          endcase
        end

        PH_PALETTE: begin
          // Entries are B, G, R, reserved
          case (comp_cnt_r)
            2'd0: comp_buf_nxt = {8'd0, data_byte};
            2'd1: comp_buf_nxt = {data_byte, comp_buf_r[7:0]};
            2'd2: begin
              res_valid        = 1'b1;
              res.kind         = KIND_PALETTE;
              res.red          = data_byte;
              res.green        = comp_buf_r[15:8];
              res.blue         = comp_buf_r[7:0];
              res.colour_index = 8'(col_r);
            end
            default: begin
              col_nxt = CNT_W'(col_inc);
              if (col_inc >= CMP_W'(pal_cnt_r)) begin
                enter_pix = 1'b1;
              end
            end
          endcase
          if (!(comp_cnt_r == 2'd3 && col_inc >= CMP_W'(pal_cnt_r))) begin
            comp_cnt_nxt = comp_cnt_r + 2'd1;
          end
        end

        PH_PIXELS: begin
          if (pos_cur < offset_r) begin
            // still before the pixel array
          end else if (pad_r != 2'd0) begin
            pad_nxt = pad_r - 2'd1;
          end else if (!true_col_r) begin
            emit_pix = 1'b1;
            pix_idx  = data_byte;
          end else begin
            // 24-bit pixels arrive B, G, R
            case (comp_cnt_r)
              2'd0: begin
                comp_buf_nxt = {8'd0, data_byte};
                comp_cnt_nxt = 2'd1;
              end
              2'd1: begin
                comp_buf_nxt = {data_byte, comp_buf_r[7:0]};
                comp_cnt_nxt = 2'd2;
              end
              default: begin
                comp_cnt_nxt = 2'd0;
                emit_pix     = 1'b1;
                pix_red      = data_byte;
                pix_green    = comp_buf_r[15:8];
                pix_blue     = comp_buf_r[7:0];
              end
            endcase
          end
        end

        default: ;
      endcase

      // Format error result
      if (fail) begin
        phase_nxt      = PH_ERROR;
        res_valid      = 1'b1;
        res.kind       = KIND_ERROR;
        res.error_code = fail_code;
      end

      // Start of pixel data, rows bottom-up
      if (enter_pix) begin
        if (width_r == '0 || height_r == '0) begin
          phase_nxt = PH_DONE;
        end else begin
          phase_nxt    = PH_PIXELS;
          row_nxt      = CNT_W'(height_m1);
          col_nxt      = '0;
          pad_nxt      = 2'd0;
          comp_cnt_nxt = 2'd0;
          comp_buf_nxt = 16'd0;
        end
      end

      // Pixel result and position advance
      if (emit_pix) begin
        res_valid        = 1'b1;
        res.kind         = KIND_PIXEL;
        res.red          = pix_red;
        res.green        = pix_green;
        res.blue         = pix_blue;
        res.colour_index = pix_idx;
        res.row          = POS_W'(row_r);
        res.column       = POS_W'(col_r);
        res.last_pixel   = (row_r == '0) && (col_inc == CMP_W'(width_r));
        col_nxt          = CNT_W'(col_inc);
        if (col_inc >= CMP_W'(width_r)) begin
          if (row_r == '0) begin
            phase_nxt = PH_DONE;
          end else begin
            row_nxt = row_r - CNT_W'(1);
            col_nxt = '0;
            // Row padding to a 4-byte boundary: w mod 4 for 24-bit, -w mod 4 for 8-bit
            pad_nxt = true_col_r ? width_r[1:0] : (2'd0 - width_r[1:0]);
          end
        end
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      pos_r      <= '0;
      shift_r    <= '0;
      width_r    <= '0;
      height_r   <= '0;
      offset_r   <= '0;
      true_col_r <= 1'b0;
      pal_cnt_r  <= '0;
      comp_buf_r <= '0;
      comp_cnt_r <= '0;
      row_r      <= '0;
      col_r      <= '0;
      pad_r      <= '0;
    end else begin
      phase_r    <= phase_nxt;
      pos_r      <= pos_nxt;
      shift_r    <= shift_nxt;
      width_r    <= width_nxt;
      height_r   <= height_nxt;
      offset_r   <= offset_nxt;
      true_col_r <= true_col_nxt;
      pal_cnt_r  <= pal_cnt_nxt;
      comp_buf_r <= comp_buf_nxt;
      comp_cnt_r <= comp_cnt_nxt;
      row_r      <= row_nxt;
      col_r      <= col_nxt;
      pad_r      <= pad_nxt;
    end
  end

endmodule

FILE: design/bmpd_out_stage.sv
// bmpd_out_stage: result register between the parser and the result channel.
// Takes a new result while the held one is being taken downstream.
// Depends on bmpd_pkg and bmpd_out_if.
module bmpd_out_stage import bmpd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  logic              res_valid,
  input  bmpd_result_t      res,
  output logic              ready_up,
  bmpd_out_if.source        out_chan
);

  logic         valid_r;
  bmpd_result_t data_r;

  // Space for a new result when empty or draining this cycle
  assign ready_up = !valid_r || out_chan.ready;

  // Valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= res_valid;
    end else if (out_chan.ready) begin
      valid_r <= 1'b0;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (load && res_valid) begin
      data_r <= res;
    end
  end

  assign out_chan.valid        = valid_r;
  assign out_chan.kind         = data_r.kind;
  assign out_chan.red          = data_r.red;
  assign out_chan.green        = data_r.green;
  assign out_chan.blue         = data_r.blue;
  assign out_chan.colour_index = data_r.colour_index;
  assign out_chan.row          = data_r.row;
  assign out_chan.column       = data_r.column;
  assign out_chan.last_pixel   = data_r.last_pixel;
  assign out_chan.error_code   = data_r.error_code;

endmodule
